FILE: src/bounded_ordered_list_engine_top_assert.svh
// assertion macros for the ordered list engine
`ifndef BOUNDED_ORDERED_LIST_ENGINE_TOP_ASSERT_SVH
`define BOUNDED_ORDERED_LIST_ENGINE_TOP_ASSERT_SVH

`ifndef ASSERT_OFF

`define BOLE_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

`define BOLE_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`else

`define BOLE_ASSERT(lbl, clk, rstn, prop, msg)

`define BOLE_ASSERT_NEVER(lbl, clk, rstn, cond, msg)

`endif

`endif

FILE: src/bole_pkg.sv
// shared types and codes for the ordered list engine
`timescale 1ns / 1ps
`default_nettype none

package bole_pkg;

    localparam int CAPACITY_DEF = 64;
    localparam int VALUE_W      = 32;
    localparam int FUNC_W       = 2;
    localparam int STATUS_W     = 2;
    localparam int OUT_CNT_W    = 7;

    localparam logic [FUNC_W-1:0] FUNC_HEAD   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_TAIL   = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_DELETE = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_SEARCH = 2'd3;

    localparam logic [STATUS_W-1:0] ST_DONE    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_MISSING = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;

    // broadcast strobes from the sequencer to every cell
    typedef struct packed {
        logic capture;
        logic resolve;
        logic shift_head;
        logic load_tail;
        logic shift_del;
    } bole_cell_ctrl_t;

endpackage

`default_nettype wire

FILE: src/bole_cell.sv
// one list cell: holds an entry, compares it, and shifts with its neighbors
`timescale 1ns / 1ps
`default_nettype none

module bole_cell #(
    parameter int IDX   = 0,
    parameter int CNT_W = 7
) (
    input  wire                            aclk,
    input  wire                            aresetn,
    input  wire bole_pkg::bole_cell_ctrl_t ctrl,
    input  wire [bole_pkg::VALUE_W-1:0]    cmd_value,
    input  wire [CNT_W-1:0]                count,
    input  wire [bole_pkg::VALUE_W-1:0]    left_val,
    input  wire [bole_pkg::VALUE_W-1:0]    right_val,
    input  wire                            seen_in,
    output logic                           seen_out,
    output logic                           seen_q,
    output logic                           first_q,
    output logic [bole_pkg::VALUE_W-1:0]   val_q
);
    import bole_pkg::*;

    localparam logic [CNT_W-1:0] IDX_C = CNT_W'(IDX);

    logic [VALUE_W-1:0] val_reg;
    logic               match_reg;
    logic               seen_reg;
    logic               first_reg;

    assign seen_out = seen_in | match_reg;
    assign seen_q   = seen_reg;
    assign first_q  = first_reg;
    assign val_q    = val_reg;

    always_ff @(posedge aclk) begin
        if (ctrl.shift_head) begin
            val_reg <= left_val;
        end else if (ctrl.load_tail && (count == IDX_C)) begin
            val_reg <= cmd_value;
        end else if (ctrl.shift_del && seen_reg) begin
            // at or behind the removed entry: pull from the right
            val_reg <= right_val;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            match_reg <= 1'b0;
            seen_reg  <= 1'b0;
            first_reg <= 1'b0;
        end else begin
            if (ctrl.capture) begin
                match_reg <= (IDX_C < count) && (val_reg == cmd_value);
            end
            if (ctrl.resolve) begin
                seen_reg  <= seen_out;
                first_reg <= match_reg & ~seen_in;
            end
        end
    end

endmodule

`default_nettype wire

FILE: src/bole_pos_enc.sv
// one-hot first-match flags to a 1-based position
`timescale 1ns / 1ps
`default_nettype none

module bole_pos_enc #(
    parameter int CAPACITY = bole_pkg::CAPACITY_DEF,
    parameter int CNT_W    = 7
) (
    input  wire  [CAPACITY-1:0] first_vec,
    output logic [CNT_W-1:0]    position
);
    import bole_pkg::*;

    always_comb begin
        position = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (first_vec[i]) begin
                position = position | CNT_W'(i + 1);
            end
        end
    end

endmodule

`default_nettype wire

FILE: src/bounded_ordered_list_engine_top.sv
// top level of the ordered list engine: sequencer, cell row and result register
// Each command is one transfer on the s_ side and yields one result transfer on the
// m_ side. The list lives in a row of CAPACITY cells, position 1 in cell 0. A command
// passes from acceptance to the next acceptance through capture of the command, a
// parallel compare in every cell, the first-match chain that ripples through the row,
// and the update cycle that shifts the cells and loads the result register. The update
// cycle waits while an earlier result is still held on m_. Commands are taken while a
// result waits. The ripple through the row of cells sets the clock limit.
`timescale 1ns / 1ps
`default_nettype none

`include "bounded_ordered_list_engine_top_assert.svh"

module bounded_ordered_list_engine_top #(
    parameter int CAPACITY = bole_pkg::CAPACITY_DEF
) (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [31:0] s_tdata,   // value[31:0]
    input  wire  [1:0]  s_tuser,   // func[1:0]
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [15:0] m_tdata,   // position[6:0], entries_held[13:7], zero pad
    output logic [1:0]  m_tuser    // status[1:0]
);
    import bole_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int POS_W = (CNT_W > OUT_CNT_W) ? CNT_W : OUT_CNT_W;
    localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);

    localparam logic [1:0] S_IDLE    = 2'd0;
    localparam logic [1:0] S_MATCH   = 2'd1;
    localparam logic [1:0] S_RESOLVE = 2'd2;
    localparam logic [1:0] S_APPLY   = 2'd3;

    logic [1:0]            state_reg, state_next;
    logic [FUNC_W-1:0]     func_reg;
    logic [VALUE_W-1:0]    value_reg;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic                  m_valid_reg;
    logic [STATUS_W-1:0]   status_reg, status_next;
    logic [OUT_CNT_W-1:0]  pos_reg, pos_next;
    logic [OUT_CNT_W-1:0]  held_reg;

    bole_cell_ctrl_t       ctrl;
    logic                  s_fire, slot_free, apply_go, full, found, is_insert;
    logic [CAPACITY:0]     seen_chain;
    logic [CAPACITY-1:0]   seen_vec, first_vec;
    logic [VALUE_W-1:0]    cell_val [CAPACITY];
    logic [CNT_W-1:0]      match_pos;
    logic [POS_W-1:0]      pos_wide, held_wide;

    assign s_tready  = (state_reg == S_IDLE);
    assign s_fire    = s_tvalid && s_tready;
    assign slot_free = !m_valid_reg || m_tready;
    assign apply_go  = (state_reg == S_APPLY) && slot_free;
    assign full      = (count_reg == CAP_C);
    assign found     = seen_vec[CAPACITY-1];
    assign is_insert = (func_reg == FUNC_HEAD) || (func_reg == FUNC_TAIL);

    always_comb begin
        ctrl.capture    = (state_reg == S_MATCH);
        ctrl.resolve    = (state_reg == S_RESOLVE);
        ctrl.shift_head = apply_go && (func_reg == FUNC_HEAD) && !full;
        ctrl.load_tail  = apply_go && (func_reg == FUNC_TAIL) && !full;
        ctrl.shift_del  = apply_go && (func_reg == FUNC_DELETE) && found;
    end

    assign seen_chain[0] = 1'b0;

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic [VALUE_W-1:0] left_v, right_v;
        if (i == 0) begin : g_head
            assign left_v = value_reg;
        end else begin : g_mid
            assign left_v = cell_val[i-1];
        end
        if (i == CAPACITY - 1) begin : g_end
            assign right_v = cell_val[i];
        end else begin : g_inner
            assign right_v = cell_val[i+1];
        end

        bole_cell #(
            .IDX   (i),
            .CNT_W (CNT_W)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .ctrl      (ctrl),
            .cmd_value (value_reg),
            .count     (count_reg),
            .left_val  (left_v),
            .right_val (right_v),
            .seen_in   (seen_chain[i]),
            .seen_out  (seen_chain[i+1]),
            .seen_q    (seen_vec[i]),
            .first_q   (first_vec[i]),
            .val_q     (cell_val[i])
        );
    end

    bole_pos_enc #(
        .CAPACITY (CAPACITY),
        .CNT_W    (CNT_W)
    ) u_pos_enc (
        .first_vec (first_vec),
        .position  (match_pos)
    );

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:    if (s_fire) begin state_next = S_MATCH; end
            S_MATCH:   state_next = S_RESOLVE;
            S_RESOLVE: state_next = S_APPLY;
            S_APPLY:   if (slot_free) begin state_next = S_IDLE; end
            default:   state_next = S_IDLE;
        endcase
    end

    always_comb begin
        count_next  = count_reg;
        status_next = ST_DONE;
        pos_wide    = '0;
        if (is_insert) begin
            if (full) begin
                status_next = ST_FULL;
            end else begin
                count_next = count_reg + CNT_W'(1);
            end
        end else if (!found) begin
            status_next = ST_MISSING;
        end else begin
            pos_wide = POS_W'(match_pos);
            if (func_reg == FUNC_DELETE) begin
                count_next = count_reg - CNT_W'(1);
            end
        end
        pos_next  = pos_wide[OUT_CNT_W-1:0];
        held_wide = POS_W'(count_next);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (apply_go) begin
                count_reg   <= count_next;
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            func_reg  <= s_tuser;
            value_reg <= s_tdata;
        end
        if (apply_go) begin
            status_reg <= status_next;
            pos_reg    <= pos_next;
            held_reg   <= held_wide[OUT_CNT_W-1:0];
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = status_reg;
    assign m_tdata  = {2'b00, held_reg, pos_reg};

    `BOLE_ASSERT_NEVER(a_count_bound, aclk, aresetn, count_reg > CAP_C, "fill count above capacity")
    `BOLE_ASSERT(a_first_onehot, aclk, aresetn, $onehot0(first_vec), "more than one first match")
    `BOLE_ASSERT(a_result_from_apply, aclk, aresetn, $rose(m_tvalid) |-> $past(state_reg == S_APPLY), "result raised outside update cycle")
    `BOLE_ASSERT(a_held_result, aclk, aresetn, (m_tvalid && !m_tready) |=> (state_reg != S_MATCH) || $past(state_reg == S_IDLE), "sequencer skipped a state")

endmodule

`default_nettype wire
